// ===== src/counting_semaphore_wait_queue_unit_assert.svh =====
// Assertion macros used by the checker file of the semaphore unit.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define CSWQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define CSWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cswq_pkg.sv =====
// Shared types, sizes and codes for the counting semaphore wait-queue unit.
// No dependencies; used by every module of the unit except cswq_ram.
`default_nettype none

package cswq_pkg;

    // Queue and field sizes
    localparam int QDEPTH      = 16;
    localparam int JOB_ID_BITS = 8;
    localparam int QIDX_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W       = $clog2(QDEPTH + 1);
    localparam int ID_PORT_W   = 8;
    localparam int ACTION_W    = 2;
    localparam int STATUS_W    = 3;
    localparam int LIMIT_W     = 8;
    localparam int HOLDER_W    = 8;

    localparam logic [HOLDER_W-1:0] HOLDER_MAX = '1;
    localparam logic [CNT_W-1:0]    QDEPTH_CNT = CNT_W'(QDEPTH);

    // Request kinds
    localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CANCEL  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HANDOVER  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTWAIT   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ERROR     = 3'd6;

    // One result as handed from the sequencer to the output stage
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ID_PORT_W-1:0] woken_job;
        logic                 woken_valid;
    } res_t;

endpackage

`default_nettype wire

// ===== src/cswq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cswq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/cswq_ctrl.sv =====
// Request sequencer: holder and waiter counters, queue scan and compaction.
// Depends on cswq_pkg; drives the waiter RAM ports.
`default_nettype none

module cswq_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request in
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [cswq_pkg::ACTION_W-1:0]        req_action,
    input  logic [cswq_pkg::JOB_ID_BITS-1:0]     req_id,
    input  logic [cswq_pkg::LIMIT_W-1:0]         limit,
    // result out
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output cswq_pkg::res_t                       res,
    // waiter RAM
    output logic                                 ram_we,
    output logic [cswq_pkg::QIDX_W-1:0]          ram_waddr,
    output logic [cswq_pkg::JOB_ID_BITS-1:0]     ram_wdata,
    output logic [cswq_pkg::QIDX_W-1:0]          ram_raddr,
    input  logic [cswq_pkg::JOB_ID_BITS-1:0]     ram_rdata
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_HEAD     = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]                           state_reg, state_next;
    logic [cswq_pkg::ACTION_W-1:0]        act_reg, act_next;
    logic [cswq_pkg::JOB_ID_BITS-1:0]     id_reg, id_next;
    logic [cswq_pkg::QIDX_W-1:0]          idx_reg, idx_next;
    logic [cswq_pkg::HOLDER_W-1:0]        holder_reg, holder_next;
    logic [cswq_pkg::CNT_W-1:0]           wcount_reg, wcount_next;
    cswq_pkg::res_t                       res_reg, res_next;
    logic                                 idx_last;

    // Current index is the last occupied queue slot
    assign idx_last = ((cswq_pkg::CNT_W'(idx_reg) + cswq_pkg::CNT_W'(1)) == wcount_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Next-state and RAM access logic
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        id_next     = id_reg;
        idx_next    = idx_reg;
        holder_next = holder_reg;
        wcount_next = wcount_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                // head of queue read goes out every idle cycle
                ram_raddr = '0;
                if (req_valid)
                begin
                    act_next = req_action;
                    id_next  = req_id;
                    idx_next = '0;
                    res_next = '{status: cswq_pkg::ST_ERROR, woken_job: '0, woken_valid: 1'b0};
                    state_next = S_DONE;
                    case (req_action)
                        cswq_pkg::ACT_ACQUIRE:
                        begin
                            if ((holder_reg <= limit) && (holder_reg != cswq_pkg::HOLDER_MAX))
                            begin
                                holder_next     = holder_reg + cswq_pkg::HOLDER_W'(1);
                                res_next.status = cswq_pkg::ST_GRANTED;
                            end
                            else if (wcount_reg == cswq_pkg::QDEPTH_CNT)
                            begin
                                res_next.status = cswq_pkg::ST_ERROR;
                            end
                            else if (wcount_reg == '0)
                            begin
                                // empty queue: no duplicate check needed
                                ram_we          = 1'b1;
                                ram_waddr       = wcount_reg[cswq_pkg::QIDX_W-1:0];
                                ram_wdata       = req_id;
                                wcount_next     = wcount_reg + cswq_pkg::CNT_W'(1);
                                res_next.status = cswq_pkg::ST_QUEUED;
                            end
                            else
                            begin
                                state_next = S_SCAN_CMP;
                            end
                        end
                        cswq_pkg::ACT_RELEASE:
                        begin
                            if (holder_reg == '0)
                            begin
                                res_next.status = cswq_pkg::ST_ERROR;
                            end
                            else if (wcount_reg != '0)
                            begin
                                state_next = S_HEAD;
                            end
                            else
                            begin
                                holder_next     = holder_reg - cswq_pkg::HOLDER_W'(1);
                                res_next.status = cswq_pkg::ST_RELEASED;
                            end
                        end
                        cswq_pkg::ACT_CANCEL:
                        begin
                            if (wcount_reg == '0)
                            begin
                                res_next.status = cswq_pkg::ST_NOTWAIT;
                            end
                            else
                            begin
                                state_next = S_SCAN_CMP;
                            end
                        end
                        default:
                        begin
                            res_next.status = cswq_pkg::ST_ERROR;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_SCAN_CMP;
            end

            // Compare one waiter against the request id
            S_SCAN_CMP:
            begin
                if (ram_rdata == id_reg)
                begin
                    if (act_reg == cswq_pkg::ACT_ACQUIRE)
                    begin
                        res_next.status = cswq_pkg::ST_ERROR;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        res_next.status = cswq_pkg::ST_CANCELLED;
                        state_next      = S_SHIFT_RD;
                    end
                end
                else if (idx_last)
                begin
                    if (act_reg == cswq_pkg::ACT_ACQUIRE)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = wcount_reg[cswq_pkg::QIDX_W-1:0];
                        ram_wdata       = id_reg;
                        wcount_next     = wcount_reg + cswq_pkg::CNT_W'(1);
                        res_next.status = cswq_pkg::ST_QUEUED;
                    end
                    else
                    begin
                        res_next.status = cswq_pkg::ST_NOTWAIT;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + cswq_pkg::QIDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            // Oldest waiter takes ownership
            S_HEAD:
            begin
                res_next.status      = cswq_pkg::ST_HANDOVER;
                res_next.woken_job   = cswq_pkg::ID_PORT_W'(ram_rdata);
                res_next.woken_valid = 1'b1;
                idx_next             = '0;
                state_next           = S_SHIFT_RD;
            end

            // Compaction: fetch the entry behind the gap
            S_SHIFT_RD:
            begin
                ram_raddr = idx_reg + cswq_pkg::QIDX_W'(1);
                if (idx_last)
                begin
                    wcount_next = wcount_reg - cswq_pkg::CNT_W'(1);
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end

            // Compaction: move it one slot forward
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + cswq_pkg::QIDX_W'(1);
                state_next = S_SHIFT_RD;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            holder_reg <= '0;
            wcount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            holder_reg <= holder_next;
            wcount_reg <= wcount_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        id_reg  <= id_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

// ===== src/counting_semaphore_wait_queue_unit.sv =====
// Top level of the counting semaphore with ordered wait queue.
// Depends on cswq_pkg, cswq_ctrl and cswq_ram.
//
//  Channel  | Signals                          | Carries
//  ---------+----------------------------------+------------------------------------
//  request  | s_tvalid s_tready s_tdata s_tuser | job_id in tdata, action in tuser
//  result   | m_tvalid m_tready m_tdata m_tuser | woken_job in tdata, status/flag in tuser
//  config   | cfg_valid cfg_ready cfg_data      | extra_holder_limit, always ready
//
// One request at a time. Grant, plain release and errors found without a queue
// scan go from idle straight to the done state; a scan reads one waiter at a
// time, alternating read and compare states, and a compaction moves one entry
// at a time, alternating read and write states. A finished result sits in the
// output register while the next request is accepted; while that register is
// full and m_tready is low the sequencer waits in its done state. Reset clears
// counters, limit and output valid; waiter RAM contents are not cleared.
`default_nettype none

module counting_semaphore_wait_queue_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cswq_pkg::ID_PORT_W-1:0]   s_tdata,   // [7:0] job_id
    input  logic [cswq_pkg::ACTION_W-1:0]    s_tuser,   // [1:0] action
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cswq_pkg::ID_PORT_W-1:0]   m_tdata,   // [7:0] woken_job
    output logic [cswq_pkg::STATUS_W:0]      m_tuser,   // [2:0] status, [3] woken_valid
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cswq_pkg::LIMIT_W-1:0]     cfg_data
);

    logic [cswq_pkg::LIMIT_W-1:0]      limit_reg;
    logic                              out_valid_reg;
    cswq_pkg::res_t                    out_reg;
    logic                              res_valid;
    logic                              res_ready;
    cswq_pkg::res_t                    res;
    logic                              ram_we;
    logic [cswq_pkg::QIDX_W-1:0]       ram_waddr;
    logic [cswq_pkg::JOB_ID_BITS-1:0]  ram_wdata;
    logic [cswq_pkg::QIDX_W-1:0]       ram_raddr;
    logic [cswq_pkg::JOB_ID_BITS-1:0]  ram_rdata;

    assign cfg_ready = 1'b1;

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    cswq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_action (s_tuser),
        .req_id     (s_tdata[cswq_pkg::JOB_ID_BITS-1:0]),
        .limit      (limit_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    cswq_ram #(
        .DEPTH (cswq_pkg::QDEPTH),
        .WIDTH (cswq_pkg::JOB_ID_BITS),
        .AW    (cswq_pkg::QIDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.woken_job;
    assign m_tuser  = {out_reg.woken_valid, out_reg.status};

endmodule

`default_nettype wire

// ===== src/cswq_checker.sv =====
// Port-level checks for the semaphore unit, bound to the top level.
// Depends on cswq_pkg and counting_semaphore_wait_queue_unit_assert.svh.
`default_nettype none

`include "counting_semaphore_wait_queue_unit_assert.svh"

module cswq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cswq_pkg::ID_PORT_W-1:0] m_tdata,
    input logic [cswq_pkg::STATUS_W:0]    m_tuser
);

    // Stalled result transaction holds
    `CSWQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Only one request in flight: no acceptance right after one
    `CSWQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request accepted while busy")

    // Woken flag set exactly on a handover
    `CSWQ_ASSERT_NOW(a_woken_flag, m_tvalid, m_tuser[cswq_pkg::STATUS_W] == (m_tuser[cswq_pkg::STATUS_W-1:0] == cswq_pkg::ST_HANDOVER), "woken flag disagrees with status")

    // Woken id is zero unless a handover
    `CSWQ_ASSERT_NOW(a_woken_zero, m_tvalid && !m_tuser[cswq_pkg::STATUS_W], m_tdata == '0, "woken id set without handover")

endmodule

bind counting_semaphore_wait_queue_unit cswq_checker u_cswq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
